// ===== rtl/core/hrf_pkg.sv =====
package hrf_pkg;

	localparam int RING_DEPTH_DEF = 4;

	localparam int S_TDATA_W = 56;
	localparam int M_TDATA_W = 24;
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;

	localparam int DIV_W   = 16;
	localparam int DIV_CNT_W = $clog2(DIV_W);
	localparam int PROD_W  = 40;

	// 60000 ms per minute: numerator of every rate test
	localparam logic [DIV_W-1:0] BPM_DIVIDEND = 16'd60000;

	localparam logic [17:0] SKIN_THRESHOLD_RST = 18'd50000;
	localparam logic [7:0]  MIN_BPM_RST        = 8'd40;
	localparam logic [7:0]  MAX_BPM_RST        = 8'd200;
	localparam logic [7:0]  OUTLIER_MARGIN_RST = 8'd30;
	localparam logic [3:0]  WARMUP_BEATS_RST   = 4'd2;
	localparam logic [3:0]  REJECT_LIMIT_RST   = 4'd3;
	localparam logic [3:0]  REJECT_SAT         = 4'd15;

	typedef enum logic [2:0] {
		BEAT_NONE      = 3'd0,
		BEAT_OUT_RANGE = 3'd1,
		BEAT_ACCEPTED  = 3'd2,
		BEAT_OUTLIER   = 3'd3,
		BEAT_FLUSHED   = 3'd4
	} beat_status_t;

	typedef enum logic [2:0] {
		REG_SKIN_THRESHOLD = 3'd0,
		REG_MIN_BPM        = 3'd1,
		REG_MAX_BPM        = 3'd2,
		REG_OUTLIER_MARGIN = 3'd3,
		REG_WARMUP_BEATS   = 3'd4,
		REG_REJECT_LIMIT   = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		MUL_MIN    = 2'd0,
		MUL_MAX    = 2'd1,
		MUL_AVG    = 2'd2,
		MUL_MARGIN = 2'd3
	} mul_sel_t;

	typedef enum logic [2:0] {
		CHK_NONE = 3'd0,
		CHK_LO   = 3'd1,
		CHK_HI   = 3'd2,
		CHK_MAG  = 3'd3,
		CHK_MRG  = 3'd4
	} chk_t;

	typedef struct packed {
		logic [17:0] skin_threshold;
		logic [7:0]  min_bpm;
		logic [7:0]  max_bpm;
		logic [7:0]  outlier_margin;
		logic [3:0]  warmup_beats;
		logic [3:0]  reject_limit;
	} cfg_t;

	typedef struct packed {
		logic     capture;
		logic     session;
		logic     no_skin;
		logic     interval;
		logic     div_start;
		logic     div_avg;
		logic     take_bpm;
		logic     mul_en;
		mul_sel_t mul_sel;
		chk_t     chk;
		logic     judge;
		logic     sum_step;
		logic     take_avg;
		logic     emit;
	} cmd_t;

	typedef struct packed {
		logic op;
		logic skin;
		logic beat;
		logic div_done;
		logic take;
		logic sum_last;
		logic out_free;
	} sts_t;

endpackage

// ===== rtl/core/hrf_cfg.sv =====
module hrf_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [hrf_pkg::ADDR_W-1:0]  paddr,
	input  logic [hrf_pkg::DATA_W-1:0]  pwdata,
	output logic [hrf_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output hrf_pkg::cfg_t               cfg
);

	hrf_pkg::cfg_t     cfg_q;
	hrf_pkg::reg_idx_t idx;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign idx    = hrf_pkg::reg_idx_t'(paddr[4:2]);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.skin_threshold <= hrf_pkg::SKIN_THRESHOLD_RST;
			cfg_q.min_bpm        <= hrf_pkg::MIN_BPM_RST;
			cfg_q.max_bpm        <= hrf_pkg::MAX_BPM_RST;
			cfg_q.outlier_margin <= hrf_pkg::OUTLIER_MARGIN_RST;
			cfg_q.warmup_beats   <= hrf_pkg::WARMUP_BEATS_RST;
			cfg_q.reject_limit   <= hrf_pkg::REJECT_LIMIT_RST;
		end else if (wr_en) begin
			unique case (idx)
				hrf_pkg::REG_SKIN_THRESHOLD: cfg_q.skin_threshold <= pwdata[17:0];
				hrf_pkg::REG_MIN_BPM:        cfg_q.min_bpm        <= pwdata[7:0];
				hrf_pkg::REG_MAX_BPM:        cfg_q.max_bpm        <= pwdata[7:0];
				hrf_pkg::REG_OUTLIER_MARGIN: cfg_q.outlier_margin <= pwdata[7:0];
				hrf_pkg::REG_WARMUP_BEATS:   cfg_q.warmup_beats   <= pwdata[3:0];
				hrf_pkg::REG_REJECT_LIMIT:   cfg_q.reject_limit   <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			hrf_pkg::REG_SKIN_THRESHOLD: prdata = 32'(cfg_q.skin_threshold);
			hrf_pkg::REG_MIN_BPM:        prdata = 32'(cfg_q.min_bpm);
			hrf_pkg::REG_MAX_BPM:        prdata = 32'(cfg_q.max_bpm);
			hrf_pkg::REG_OUTLIER_MARGIN: prdata = 32'(cfg_q.outlier_margin);
			hrf_pkg::REG_WARMUP_BEATS:   prdata = 32'(cfg_q.warmup_beats);
			hrf_pkg::REG_REJECT_LIMIT:   prdata = 32'(cfg_q.reject_limit);
			default:                     prdata = '0;
		endcase
	end

endmodule

// ===== rtl/core/hrf_div.sv =====
// Restoring divider, one quotient bit per cycle. A zero divisor yields all ones.
module hrf_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [hrf_pkg::DIV_W-1:0]  dividend,
	input  logic [31:0]                divisor,
	output logic                       done,
	output logic [hrf_pkg::DIV_W-1:0]  quotient
);

	localparam int DW = hrf_pkg::DIV_W;
	localparam int CW = hrf_pkg::DIV_CNT_W;

	logic [DW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic [31:0]   dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   shifted;
	logic [DW:0]   diff;
	logic          fits;

	assign shifted  = {rem_q, quo_q[DW-1]};
	assign fits     = 32'(shifted) >= dvs_q;
	assign diff     = shifted - dvs_q[DW:0];
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			// remainder never exceeds the dividend bits shifted in so far
			rem_q <= fits ? diff[DW-1:0] : shifted[DW-1:0];
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

endmodule

// ===== rtl/core/hrf_dp.sv =====
module hrf_dp #(
	parameter int RING_DEPTH = hrf_pkg::RING_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hrf_pkg::cfg_t                 cfg,
	input  hrf_pkg::cmd_t                 cmd,
	output hrf_pkg::sts_t                 sts,
	input  logic                          s_tuser,
	input  logic [hrf_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [hrf_pkg::M_TDATA_W-1:0] m_tdata
);

	localparam int CNT_W  = $clog2(RING_DEPTH + 1);
	localparam int IDX_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int SUM_W  = 8 + CNT_W;
	localparam int PW     = hrf_pkg::PROD_W;
	localparam logic [PW-1:0] NUM = PW'(hrf_pkg::BPM_DIVIDEND);

	// captured item
	logic        op_q, skin_q, beat_q;
	logic [31:0] now_q;

	// filter state
	logic [7:0]       ring [RING_DEPTH];
	logic [IDX_W-1:0] slot_q;
	logic [CNT_W-1:0] valid_q;
	logic [3:0]       reject_q;
	logic [31:0]      last_q;
	logic [7:0]       avg_q;

	// per-beat working registers
	logic [31:0]      d_q;
	logic [PW-1:0]    prod_q;
	logic [PW-1:0]    mag_q;
	logic             lo_ok_q, hi_ok_q, mrg_ok_q;
	logic [SUM_W-1:0] sum_q;
	logic [IDX_W-1:0] idx_q;
	logic [7:0]       inst_q;
	hrf_pkg::beat_status_t status_q;

	// result register
	logic       out_valid_q;
	logic [7:0] out_avg_q, out_inst_q;
	logic       out_skin_q;
	hrf_pkg::beat_status_t out_status_q;

	logic [7:0]            mul_a;
	logic                  in_range, accept, flush;
	logic [3:0]            rej_next;
	logic                  div_done;
	logic [hrf_pkg::DIV_W-1:0] quo;
	logic [hrf_pkg::DIV_W-1:0] div_num;
	logic [31:0]           div_den;
	logic [IDX_W-1:0]      slot_next;

	assign in_range = (d_q != 32'd0) & lo_ok_q & hi_ok_q;
	assign accept   = (8'(valid_q) < 8'(cfg.warmup_beats)) | mrg_ok_q;
	assign rej_next = (reject_q == hrf_pkg::REJECT_SAT) ? reject_q : reject_q + 4'd1;
	assign flush    = rej_next >= cfg.reject_limit;
	assign slot_next = (slot_q == IDX_W'(RING_DEPTH - 1)) ? '0 : slot_q + 1'b1;

	assign div_num = cmd.div_avg ? hrf_pkg::DIV_W'(sum_q) : hrf_pkg::BPM_DIVIDEND;
	assign div_den = cmd.div_avg ? 32'(valid_q) : d_q;

	hrf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (quo)
	);

	always_comb begin
		unique case (cmd.mul_sel)
			hrf_pkg::MUL_MIN:    mul_a = cfg.min_bpm;
			hrf_pkg::MUL_MAX:    mul_a = cfg.max_bpm;
			hrf_pkg::MUL_AVG:    mul_a = avg_q;
			hrf_pkg::MUL_MARGIN: mul_a = cfg.outlier_margin;
			default:             mul_a = '0;
		endcase
	end

	assign sts.op       = op_q;
	assign sts.skin     = skin_q;
	assign sts.beat     = beat_q;
	assign sts.div_done = div_done;
	assign sts.take     = in_range & accept;
	assign sts.sum_last = idx_q == IDX_W'(RING_DEPTH - 1);
	assign sts.out_free = ~out_valid_q | m_tready;

	// input capture and working registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= s_tuser;
			skin_q   <= s_tdata[17:0] > cfg.skin_threshold;
			beat_q   <= s_tdata[18];
			now_q    <= s_tdata[50:19];
			status_q <= hrf_pkg::BEAT_NONE;
			inst_q   <= '0;
		end
		if (cmd.interval) d_q <= now_q - last_q;
		if (cmd.take_bpm) inst_q <= (|quo[15:8]) ? 8'hFF : quo[7:0];
		if (cmd.mul_en)   prod_q <= PW'(mul_a) * PW'(d_q);
		unique case (cmd.chk)
			hrf_pkg::CHK_NONE: ;
			hrf_pkg::CHK_LO:   lo_ok_q  <= prod_q < NUM;
			hrf_pkg::CHK_HI:   hi_ok_q  <= prod_q > NUM;
			hrf_pkg::CHK_MAG:  mag_q    <= (prod_q >= NUM) ? prod_q - NUM : NUM - prod_q;
			hrf_pkg::CHK_MRG:  mrg_ok_q <= mag_q < prod_q;
			default: ;
		endcase
		if (cmd.judge) begin
			if (!in_range) status_q <= hrf_pkg::BEAT_OUT_RANGE;
			else if (accept) status_q <= hrf_pkg::BEAT_ACCEPTED;
			else if (flush) status_q <= hrf_pkg::BEAT_FLUSHED;
			else status_q <= hrf_pkg::BEAT_OUTLIER;
			sum_q <= '0;
			idx_q <= '0;
		end
		if (cmd.sum_step) begin
			if (CNT_W'(idx_q) < valid_q) sum_q <= sum_q + SUM_W'(ring[idx_q]);
			idx_q <= idx_q + 1'b1;
		end
	end

	// ring entries past the valid count are never summed, so no clearing
	always_ff @(posedge clk) begin
		if (cmd.judge && in_range && accept) ring[slot_q] <= inst_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q   <= '0;
			valid_q  <= '0;
			reject_q <= '0;
			avg_q    <= '0;
			last_q   <= '0;
		end else begin
			if (cmd.session || cmd.no_skin) begin
				slot_q   <= '0;
				valid_q  <= '0;
				reject_q <= '0;
				avg_q    <= '0;
			end
			if (cmd.session || cmd.interval) last_q <= now_q;
			if (cmd.judge && in_range) begin
				if (accept) begin
					slot_q   <= slot_next;
					reject_q <= '0;
					if (valid_q < CNT_W'(RING_DEPTH)) valid_q <= valid_q + 1'b1;
				end else if (flush) begin
					slot_q   <= '0;
					valid_q  <= '0;
					reject_q <= '0;
					avg_q    <= '0;
				end else begin
					reject_q <= rej_next;
				end
			end
			if (cmd.take_avg) avg_q <= quo[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_avg_q    <= avg_q;
			out_skin_q   <= skin_q;
			out_status_q <= status_q;
			out_inst_q   <= inst_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, out_inst_q, out_status_q, out_skin_q, out_avg_q};

endmodule

// ===== rtl/core/hrf_ctrl.sv =====
module hrf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  hrf_pkg::sts_t sts,
	output hrf_pkg::cmd_t cmd
);

	typedef enum logic [13:0] {
		S_IDLE     = 14'b00000000000001,
		S_DECIDE   = 14'b00000000000010,
		S_DIV_BPM  = 14'b00000000000100,
		S_WAIT_BPM = 14'b00000000001000,
		S_MUL_MIN  = 14'b00000000010000,
		S_MUL_MAX  = 14'b00000000100000,
		S_MUL_AVG  = 14'b00000001000000,
		S_MUL_MRG  = 14'b00000010000000,
		S_CHK_MRG  = 14'b00000100000000,
		S_JUDGE    = 14'b00001000000000,
		S_SUM      = 14'b00010000000000,
		S_DIV_AVG  = 14'b00100000000000,
		S_WAIT_AVG = 14'b01000000000000,
		S_FINISH   = 14'b10000000000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	assign s_tready = state_q == S_IDLE;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECIDE;
				end
			end
			S_DECIDE: begin
				priority if (sts.op) begin
					cmd.session = 1'b1;
					state_d     = S_FINISH;
				end else if (!sts.skin) begin
					cmd.no_skin = 1'b1;
					state_d     = S_FINISH;
				end else if (sts.beat) begin
					cmd.interval = 1'b1;
					state_d      = S_DIV_BPM;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_DIV_BPM: begin
				cmd.div_start = 1'b1;
				state_d       = S_WAIT_BPM;
			end
			S_WAIT_BPM: begin
				if (sts.div_done) begin
					cmd.take_bpm = 1'b1;
					state_d      = S_MUL_MIN;
				end
			end
			S_MUL_MIN: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = hrf_pkg::MUL_MIN;
				state_d     = S_MUL_MAX;
			end
			S_MUL_MAX: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = hrf_pkg::MUL_MAX;
				cmd.chk     = hrf_pkg::CHK_LO;
				state_d     = S_MUL_AVG;
			end
			S_MUL_AVG: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = hrf_pkg::MUL_AVG;
				cmd.chk     = hrf_pkg::CHK_HI;
				state_d     = S_MUL_MRG;
			end
			S_MUL_MRG: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = hrf_pkg::MUL_MARGIN;
				cmd.chk     = hrf_pkg::CHK_MAG;
				state_d     = S_CHK_MRG;
			end
			S_CHK_MRG: begin
				cmd.chk = hrf_pkg::CHK_MRG;
				state_d = S_JUDGE;
			end
			S_JUDGE: begin
				cmd.judge = 1'b1;
				state_d   = sts.take ? S_SUM : S_FINISH;
			end
			S_SUM: begin
				cmd.sum_step = 1'b1;
				if (sts.sum_last) state_d = S_DIV_AVG;
			end
			S_DIV_AVG: begin
				cmd.div_start = 1'b1;
				cmd.div_avg   = 1'b1;
				state_d       = S_WAIT_AVG;
			end
			S_WAIT_AVG: begin
				if (sts.div_done) begin
					cmd.take_avg = 1'b1;
					state_d      = S_FINISH;
				end
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ===== rtl/core/heart_rate_average_filter_core.sv =====
// Heart rate averaging filter with outlier rejection.
// Input stream (s_*): one request per optical sample, carrying the sample, a beat
// flag from an external detector and a millisecond timestamp; s_tuser = 1 starts
// a session instead. Every request yields exactly one result on m_*.
// A beat with skin present divides 60000 by the beat interval, tests the rate
// against the configured range and the running average, and on acceptance pushes
// it into a ring of RING_DEPTH entries and recomputes the average.
// A request without a beat (session start, no skin, plain sample) goes straight to its
// result; a beat goes through the rate division and the range tests, and if accepted
// also through a ring sweep and a second division for the average. One shared 16-step
// restoring divider serves both divisions, a shared 8x32 multiplier the four rate tests.
// One request is worked on at a time; s_tready is high only while idle.
// A finished result sits in the output register until taken, and the next
// request is accepted meanwhile; if the receiver still stalls when that one is
// done, the controller holds in its final state.
// Reset (arst_n low) restores the register defaults, clears the filter and the
// last beat time, and drops any pending result.
// Configuration is an APB slave, register i at byte address 4*i; write only while idle.
module heart_rate_average_filter_core #(
	parameter int RING_DEPTH = hrf_pkg::RING_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// ir_level[17:0], beat_seen[18], now_ms[50:19], zero fill[55:51]
	input  logic [hrf_pkg::S_TDATA_W-1:0] s_tdata,
	// op: 0 sample, 1 start session
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// average_bpm[7:0], skin_present[8], beat_status[11:9], instant_bpm[19:12], zero fill[23:20]
	output logic [hrf_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [hrf_pkg::ADDR_W-1:0]    paddr,
	input  logic [hrf_pkg::DATA_W-1:0]    pwdata,
	output logic [hrf_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);

	hrf_pkg::cfg_t cfg;
	hrf_pkg::cmd_t cmd;
	hrf_pkg::sts_t sts;

	// register file
	hrf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer: walks a beat through divide, range tests, ring update, average
	hrf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// filter state, arithmetic and the result register
	hrf_dp #(
		.RING_DEPTH (RING_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd      (cmd),
		.sts      (sts),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ===== rtl/core/hrf_chk.sv =====
module hrf_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [hrf_pkg::M_TDATA_W-1:0] m_tdata
);

	// a result that waits holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one request in flight: ready drops right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request accepted while busy");

	// any beat outcome implies skin was present
	a_beat_skin: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[11:9] != hrf_pkg::BEAT_NONE) |-> m_tdata[8])
		else $error("beat status without skin");

	// a flush by outliers leaves no average
	a_flush_avg: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[11:9] == hrf_pkg::BEAT_FLUSHED) |-> m_tdata[7:0] == 8'd0)
		else $error("average survived an outlier flush");

endmodule

bind heart_rate_average_filter_core hrf_chk u_hrf_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
